/* design/automatic_gain_control_core_defines.svh */
// Assertion macros for the file that checks the gain control core.
`ifndef AUTOMATIC_GAIN_CONTROL_CORE_DEFINES_SVH
`define AUTOMATIC_GAIN_CONTROL_CORE_DEFINES_SVH

// Checked only outside reset.
`define AGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define AGC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/agc_pkg.sv */
package agc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 32;
  localparam int STEP_NUM_W = 12;
  localparam int STEP_SHIFT = 16;

  localparam logic [14:0] MAX_LEVEL = 15'h7FFF;
  localparam logic [STEP_NUM_W-1:0] STEP_NUM = 12'd3277;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

  // Controller sequence for one request.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_SCALE,
    ST_UPDATE,
    ST_CLAMP,
    ST_PRODUCT,
    ST_DONE
  } agc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic diff_en;
    logic scale_en;
    logic update_en;
    logic clamp_en;
    logic prod_en;
    logic out_load;
  } agc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_div;
    logic div_last;
  } agc_status_t;

endpackage

/* design/agc_in_if.sv */
interface agc_in_if import agc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink (input valid, input sample, input end_of_block, output ready);
endinterface

/* design/agc_out_if.sv */
interface agc_out_if import agc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic saturated;
  logic end_of_block_out;

  modport source (output valid, output sample_out, output saturated,
                  output end_of_block_out, input ready);
  modport sink (input valid, input sample_out, input saturated,
                input end_of_block_out, output ready);
endinterface

/* design/automatic_gain_control_core.sv */
// Channel   Dir  Fields
// in_chan   in   sample, end_of_block
// out_chan  out  sample_out, saturated, end_of_block_out
// cfg       in   cfg_we, cfg_wdata (gain limit)
//
// A request is processed to completion before the next one is accepted; the
// gain divider produces one quotient bit per cycle.
// Samples with magnitude 0 or 1 bypass the divider.
// Reset is synchronous; it restores the gain and the gain limit to 65536.
// A finished result waits in the output register while the next request is
// accepted; the core stalls only at its last step if that register is full.
module automatic_gain_control_core import agc_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  agc_in_if.sink            in_chan,
  agc_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata
);

  agc_cmd_t    cmd;
  agc_status_t status;
  logic        in_ready;
  logic        out_valid;

  // Sequencer.
  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Divider, gain update and output arithmetic.
  agc_datapath #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sample           (in_chan.sample),
    .end_of_block     (in_chan.end_of_block),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .status           (status),
    .sample_out       (out_chan.sample_out),
    .saturated        (out_chan.saturated),
    .end_of_block_out (out_chan.end_of_block_out)
  );

  assign in_chan.ready = in_ready;
  assign out_chan.valid = out_valid;

`include "automatic_gain_control_core_defines.svh"

  // Once a request is accepted, no other is taken while it is processed.
  `AGC_ASSERT(a_busy_after_accept, in_chan.valid && in_chan.ready |=> !in_chan.ready, "request accepted while busy")
  // A result is never written over one that was not taken.
  `AGC_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_chan.valid || out_chan.ready), "result overwritten")
  // Output valid rises only when a result is loaded.
  `AGC_ASSERT(a_valid_source, $rose(out_chan.valid) |-> $past(cmd.out_load), "spurious output valid")
  // The core is ready for a request right after reset.
  `AGC_ASSERT_ALWAYS(a_ready_after_reset, rst |=> in_chan.ready && !out_chan.valid, "not idle after reset")

endmodule

/* design/agc_ctrl.sv */
module agc_ctrl import agc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_ready,
  input  agc_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output agc_cmd_t    cmd
);

  agc_state_t state, state_next;
  logic out_valid_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.skip_div) begin
          state_next = ST_DIFF;
        end else begin
          cmd.div_step = 1'b1;
          if (status.div_last) state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update_en = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_next = ST_PRODUCT;
      end
      ST_PRODUCT: begin
        cmd.prod_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The output stays valid until the sink takes it.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* design/agc_datapath.sv */
module agc_datapath import agc_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  agc_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       end_of_block,
  input  logic                       cfg_we,
  input  logic [GAIN_W-1:0]          cfg_wdata,
  output agc_status_t                status,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       saturated,
  output logic                       end_of_block_out
);

  localparam int NW = 15 + GAIN_FRACTION_BITS;
  localparam int QW = (NW > GAIN_W) ? NW : GAIN_W + 1;
  localparam int CW = $clog2(NW);
  localparam int SW = GAIN_W + STEP_NUM_W;
  localparam int PW = SAMPLE_W + GAIN_W;
  localparam logic [NW-1:0] DIV_NUM = {MAX_LEVEL, {GAIN_FRACTION_BITS{1'b0}}};
  localparam logic [PW-1:0] LIMIT = {{(PW-15){1'b0}}, MAX_LEVEL} << GAIN_FRACTION_BITS;

  logic [GAIN_W-1:0]   gain_limit;
  logic [GAIN_W-1:0]   gain;
  logic [SAMPLE_W-1:0] mag;
  logic                neg;
  logic                eob;
  logic [NW-1:0]       nq;
  logic [SAMPLE_W-1:0] rem;
  logic [CW-1:0]       cnt;
  logic [GAIN_W-1:0]   diff;
  logic                up;
  logic [SW-1:0]       scaled;
  logic [PW-1:0]       prod;

  logic [SAMPLE_W-1:0] mag_in;
  logic [SAMPLE_W:0]   trial;
  logic                ge;
  logic [QW-1:0]       q_ext;
  logic [GAIN_W-1:0]   target;
  logic [SW-STEP_SHIFT-1:0] step_floor;
  logic                step_frac;
  logic [GAIN_W-1:0]   gain_upd;
  logic [PW-1:0]       prod_shift;
  logic [14:0]         level;
  logic                clip;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_limit <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_limit <= cfg_wdata;
    end
  end

  // Magnitude of the incoming sample; the most negative value maps to 32768.
  assign mag_in = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
      neg <= sample[SAMPLE_W-1];
      eob <= end_of_block;
    end
  end

  // Restoring divider, one quotient bit per cycle, quotient shifts into nq.
  assign trial = {rem, nq[NW-1]};
  assign ge = trial >= {1'b0, mag};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nq <= DIV_NUM;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      nq <= {nq[NW-2:0], ge};
      rem <= ge ? SAMPLE_W'(trial - {1'b0, mag}) : trial[SAMPLE_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign status.skip_div = (mag[SAMPLE_W-1:1] == '0);
  assign status.div_last = (cnt == CW'(NW - 1));

  // Target gain: the gain limit when the divider is skipped, else the quotient, saturated if it does not fit.
  assign q_ext = QW'(nq);
  always_comb begin
    if (status.skip_div) begin
      target = gain_limit;
    end else if (|q_ext[QW-1:GAIN_W]) begin
      target = '1;
    end else begin
      target = q_ext[GAIN_W-1:0];
    end
  end

  // Distance to the target and its direction.
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      up <= target >= gain;
      diff <= (target >= gain) ? target - gain : gain - target;
    end
  end

  // Scale the distance by the step fraction.
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      scaled <= SW'(diff) * SW'(STEP_NUM);
    end
  end

  // Step toward the target: floor when rising, ceiling when falling.
  assign step_floor = scaled[SW-1:STEP_SHIFT];
  assign step_frac = |scaled[STEP_SHIFT-1:0];
  assign gain_upd = up ? gain + GAIN_W'(step_floor)
                       : gain - GAIN_W'(step_floor) - GAIN_W'(step_frac);

  // Running gain: update, then clamp to the configured limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cmd.update_en) begin
      gain <= gain_upd;
    end else if (cmd.clamp_en && gain > gain_limit) begin
      gain <= gain_limit;
    end
  end

  // Apply the gain to the sample magnitude.
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= PW'(mag) * PW'(gain);
    end
  end

  // Truncate and saturate, then restore the sign.
  assign prod_shift = prod >> GAIN_FRACTION_BITS;
  assign clip = prod > LIMIT;
  assign level = clip ? MAX_LEVEL : prod_shift[14:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= neg ? SAMPLE_W'(-{1'b0, level}) : SAMPLE_W'({1'b0, level});
      saturated <= clip;
      end_of_block_out <= eob;
    end
  end

endmodule
